### sv/single_button_code_lock_assert.svh
// assertion macros used by the checker file
`ifndef SINGLE_BUTTON_CODE_LOCK_ASSERT_SVH
`define SINGLE_BUTTON_CODE_LOCK_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SBCL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SBCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/sbcl_pkg.sv
package sbcl_pkg;

	// default counter width for holdoff and idle counters
	localparam int SBCL_COUNT_BITS = 8;

	// configuration register indexes
	localparam logic [2:0] REG_CODE_FIRST    = 3'd0;
	localparam logic [2:0] REG_CODE_SECOND   = 3'd1;
	localparam logic [2:0] REG_CODE_THIRD    = 3'd2;
	localparam logic [2:0] REG_BATTERY_LIMIT = 3'd3;
	localparam logic [2:0] REG_COMMIT_TICKS  = 3'd4;
	localparam logic [2:0] REG_HOLDOFF_TICKS = 3'd5;

	localparam int CFG_DATA_BITS = 10;

	// register reset values
	localparam logic [3:0] CODE_DIGIT_RST    = 4'd1;
	localparam logic [9:0] BATTERY_LIMIT_RST = 10'd500;
	localparam logic [7:0] COMMIT_TICKS_RST  = 8'd10;
	localparam logic [7:0] HOLDOFF_TICKS_RST = 8'd2;

	// digit and position codes
	localparam logic [3:0] DIGIT_MAX = 4'd9;
	localparam logic [1:0] POS_FIRST  = 2'd1;
	localparam logic [1:0] POS_SECOND = 2'd2;
	localparam logic [1:0] POS_THIRD  = 2'd3;

	typedef struct packed {
		logic       button_edge;
		logic [9:0] battery_sample;
	} in_t;

	typedef struct packed {
		logic       locked;
		logic       battery_low;
		logic       code_accepted;
		logic [1:0] digit_position;
		logic [3:0] entered_value;
		logic       value_pending;
	} out_t;

endpackage

### sv/single_button_code_lock.sv
// Single-button code lock. One input word is one scheduler tick (button edge flag
// and battery sample); every accepted word yields exactly one result word with
// the lock, battery and digit-entry status after that tick. The tick update is a
// single pass of small counters and compares between the state registers and the
// output register, so a word can be accepted every cycle while in_stall is low,
// and its result is registered. A two-word output buffer (output register plus
// skid stage) keeps input acceptance going for one more word while the output
// is stalled; in_stall rises only once both are full. Configuration writes take
// effect on the next tick and should be made while no word is in flight.
module single_button_code_lock import sbcl_pkg::*; #(
	parameter int COUNT_BITS = SBCL_COUNT_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_t                      in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_t                     out_data,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	logic step;
	logic full;
	out_t res;

	assign in_stall = full;
	assign step     = in_valid && !full;

	// tick logic and lock state
	sbcl_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.in_data   (in_data),
		.res       (res)
	);

	// result buffering
	sbcl_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### sv/sbcl_core.sv
module sbcl_core import sbcl_pkg::*; #(
	parameter int COUNT_BITS = SBCL_COUNT_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     step,
	input  in_t                      in_data,
	output out_t                     res
);

	localparam int WIDE_BITS = (COUNT_BITS > 8) ? COUNT_BITS : 8;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam int HOLD_RST_INT = (int'(HOLDOFF_TICKS_RST) > (2**COUNT_BITS - 1)) ?
		(2**COUNT_BITS - 1) : int'(HOLDOFF_TICKS_RST);
	localparam logic [COUNT_BITS-1:0] HOLD_RST = COUNT_BITS'(HOLD_RST_INT);

	// configuration registers
	logic [3:0] code_first_q, code_second_q, code_third_q;
	logic [9:0] battery_limit_q;
	logic [7:0] commit_ticks_q, holdoff_ticks_q;

	// lock state
	logic                  low_q, lock_q, accept_q, pend_q, valid_q;
	logic [COUNT_BITS-1:0] hold_q, idle_q;
	logic [1:0]            pos_q;
	logic [3:0]            digit_q;

	logic                  low_d, lock_d, accept_d, pend_d, valid_d;
	logic [COUNT_BITS-1:0] hold_d, idle_d, idle_inc;
	logic [1:0]            pos_d;
	logic [3:0]            digit_d;
	logic [COUNT_BITS-1:0] hold_lim, commit_lim;
	logic [WIDE_BITS-1:0]  hold_w, commit_w, max_w;
	logic                  press_in, want_ok, accept_mid;
	logic [3:0]            want;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_first_q    <= CODE_DIGIT_RST;
			code_second_q   <= CODE_DIGIT_RST;
			code_third_q    <= CODE_DIGIT_RST;
			battery_limit_q <= BATTERY_LIMIT_RST;
			commit_ticks_q  <= COMMIT_TICKS_RST;
			holdoff_ticks_q <= HOLDOFF_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CODE_FIRST:    code_first_q    <= cfg_data[3:0];
				REG_CODE_SECOND:   code_second_q   <= cfg_data[3:0];
				REG_CODE_THIRD:    code_third_q    <= cfg_data[3:0];
				REG_BATTERY_LIMIT: battery_limit_q <= cfg_data[9:0];
				REG_COMMIT_TICKS:  commit_ticks_q  <= cfg_data[7:0];
				REG_HOLDOFF_TICKS: holdoff_ticks_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// tick limits clipped to the counter range
	always_comb begin
		max_w      = WIDE_BITS'(COUNT_MAX);
		hold_w     = WIDE_BITS'(holdoff_ticks_q);
		commit_w   = WIDE_BITS'(commit_ticks_q);
		hold_lim   = (hold_w > max_w) ? COUNT_MAX : hold_w[COUNT_BITS-1:0];
		commit_lim = (commit_w > max_w) ? COUNT_MAX : commit_w[COUNT_BITS-1:0];
	end

	// expected digit for the current position
	always_comb begin
		want_ok = 1'b1;
		unique case (pos_q)
			POS_FIRST:  want = code_first_q;
			POS_SECOND: want = code_second_q;
			POS_THIRD:  want = code_third_q;
			default: begin
				want    = '0;
				want_ok = 1'b0;
			end
		endcase
	end

	// next state for one tick
	always_comb begin
		// debounce: any edge reloads the holdoff counter
		press_in = pend_q | (in_data.button_edge & (hold_q == '0));
		if (in_data.button_edge) begin
			hold_d = hold_lim;
		end else if (hold_q != '0) begin
			hold_d = hold_q - COUNT_BITS'(1);
		end else begin
			hold_d = hold_q;
		end

		pend_d     = press_in;
		digit_d    = digit_q;
		valid_d    = valid_q;
		idle_d     = idle_q;
		pos_d      = pos_q;
		accept_mid = accept_q;
		idle_inc   = (idle_q == COUNT_MAX) ? idle_q : idle_q + COUNT_BITS'(1);

		// digit entry and commit
		if (press_in && !accept_q) begin
			pend_d = 1'b0;
			if (!valid_q || digit_q == '0) begin
				digit_d = 4'd1;
			end else if (digit_q < DIGIT_MAX) begin
				digit_d = digit_q + 4'd1;
			end else begin
				digit_d = '0;
			end
			valid_d = 1'b1;
			idle_d  = '0;
		end else if (valid_q) begin
			idle_d = idle_inc;
			if (idle_inc >= commit_lim) begin
				if (want_ok && digit_q == want) begin
					if (pos_q == POS_THIRD) begin
						pos_d      = POS_FIRST;
						accept_mid = !low_q || !lock_q;
					end else begin
						pos_d = pos_q + 2'd1;
					end
				end else begin
					pos_d = POS_FIRST;
				end
				valid_d = 1'b0;
				digit_d = '0;
				pend_d  = 1'b0;
				idle_d  = '0;
			end
		end

		// battery compare
		low_d = (in_data.battery_sample <= battery_limit_q);

		// lock toggle on an accepted code
		lock_d   = lock_q;
		accept_d = accept_mid;
		if (lock_q) begin
			if (accept_mid && !low_d) begin
				lock_d   = 1'b0;
				accept_d = 1'b0;
			end
		end else if (accept_mid) begin
			lock_d   = 1'b1;
			accept_d = 1'b0;
		end
	end

	// state registers, updated once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= 1'b1;
			lock_q   <= 1'b1;
			accept_q <= 1'b0;
			pend_q   <= 1'b0;
			hold_q   <= HOLD_RST;
			idle_q   <= '0;
			pos_q    <= POS_FIRST;
			digit_q  <= '0;
			valid_q  <= 1'b0;
		end else if (step) begin
			low_q    <= low_d;
			lock_q   <= lock_d;
			accept_q <= accept_d;
			pend_q   <= pend_d;
			hold_q   <= hold_d;
			idle_q   <= idle_d;
			pos_q    <= pos_d;
			digit_q  <= digit_d;
			valid_q  <= valid_d;
		end
	end

	// result word is the state after the tick
	always_comb begin
		res.locked         = lock_d;
		res.battery_low    = low_d;
		res.code_accepted  = accept_d;
		res.digit_position = pos_d;
		res.entered_value  = digit_d;
		res.value_pending  = valid_d;
	end

endmodule

### sv/sbcl_obuf.sv
module sbcl_obuf import sbcl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  out_t push_data,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);

	logic out_vld_q, skid_vld_q;
	out_t out_q, skid_q;
	logic take;

	assign take      = out_vld_q && !out_stall;
	assign full      = skid_vld_q;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// occupancy of output register and skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			out_vld_q <= 1'b1;
			if (out_vld_q && !take) begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload moves
	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_vld_q || take) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end else if (take && skid_vld_q) begin
			out_q <= skid_q;
		end
	end

endmodule

### sv/sbcl_checker.sv
`include "single_button_code_lock_assert.svh"

module sbcl_checker import sbcl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	// a stalled result word holds
	`SBCL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result word changed")

	// position always names one of the three digits
	`SBCL_ASSERT_NOW(a_pos_range, out_valid, out_data.digit_position != 2'd0, "digit position out of range")

	// no pending value means a cleared digit
	`SBCL_ASSERT_NOW(a_value_clear, out_valid && !out_data.value_pending, out_data.entered_value == 4'd0, "digit not cleared")

	// an accepted code only waits while locked with a low battery
	`SBCL_ASSERT_NOW(a_accept_wait, out_valid && out_data.code_accepted, out_data.locked && out_data.battery_low, "accepted code not applied")

endmodule

bind single_button_code_lock sbcl_checker u_sbcl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
